// ----- rtl/core/brf_pkg.sv -----
// Shared types and codes for the banked register file core.
// Holds the request and response word types and the target and mode codes.
// No dependencies.
`default_nettype none

package brf_pkg;

	localparam int INT_REGS_DEF   = 16;
	localparam int DATA_REGS_DEF  = 16;
	localparam int FLOAT_REGS_DEF = 16;

	localparam int FLAG_W = 10;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic [3:0] TGT_INT   = 4'd0;
	localparam logic [3:0] TGT_DATA  = 4'd1;
	localparam logic [3:0] TGT_FLOAT = 4'd2;
	localparam logic [3:0] TGT_FLAGS = 4'd3;
	localparam logic [3:0] TGT_SP    = 4'd4;
	localparam logic [3:0] TGT_PC    = 4'd5;
	localparam logic [3:0] TGT_LINK  = 4'd6;
	localparam logic [3:0] TGT_ASN   = 4'd7;
	localparam logic [3:0] TGT_SUPER = 4'd8;

	typedef struct packed {
		logic        mode;
		logic [3:0]  target;
		logic [4:0]  reg_index;
		logic [63:0] write_value;
	} req_word_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        in_supervisor;
	} rsp_word_t;

	// One access presented to the register storage in a given cycle.
	typedef struct packed {
		logic      en;
		req_word_t word;
	} access_t;

endpackage

`default_nettype wire

// ----- rtl/core/brf_store.sv -----
// Banked register storage and the access logic in front of it.
// Performs one read or write per enabled cycle and returns the response word.
// Depends on brf_pkg.
`default_nettype none

module brf_store #(
	parameter int INT_REGS   = brf_pkg::INT_REGS_DEF,
	parameter int DATA_REGS  = brf_pkg::DATA_REGS_DEF,
	parameter int FLOAT_REGS = brf_pkg::FLOAT_REGS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire brf_pkg::access_t  acc,
	output brf_pkg::rsp_word_t     result
);
	import brf_pkg::*;

	localparam int IW  = $clog2(INT_REGS);
	localparam int DW  = $clog2(DATA_REGS);
	localparam int DSW = $clog2(DATA_REGS - 1);
	localparam int FW  = (FLOAT_REGS > 1) ? $clog2(FLOAT_REGS) : 1;

	logic [31:0]       int_user_q  [INT_REGS];
	logic [31:0]       int_super_q [INT_REGS];
	logic [31:0]       data_user_q [DATA_REGS];
	logic [31:0]       data_super_q[DATA_REGS-1];
	logic [63:0]       float_q     [FLOAT_REGS];
	logic [FLAG_W-1:0] flags_user_q;
	logic [FLAG_W-1:0] flags_super_q;
	logic              sup_q;
	logic [31:0]       asn_q;

	logic        wr;
	logic [4:0]  i_idx;
	logic [4:0]  d_idx;
	logic        i_ok;
	logic        d_ok;
	logic        f_ok;
	logic        d_super;
	logic [31:0] i_rd;
	logic [31:0] d_rd;
	logic [63:0] f_rd;
	logic [63:0] rd;
	logic        i_we;
	logic        d_we;
	logic        f_we;
	logic        flags_we;
	logic        asn_we;
	logic        sup_we;
	logic [31:0] v32;

	assign wr  = acc.en && (acc.word.mode == MODE_WRITE);
	assign v32 = acc.word.write_value[31:0];

	// Link register is the last integer entry; stack pointer and program counter
	// are the last two data entries.
	assign i_idx = (acc.word.target == TGT_LINK) ? 5'(INT_REGS - 1) : acc.word.reg_index;
	always_comb begin
		case (acc.word.target)
			TGT_SP:  d_idx = 5'(DATA_REGS - 2);
			TGT_PC:  d_idx = 5'(DATA_REGS - 1);
			default: d_idx = acc.word.reg_index;
		endcase
	end

	assign i_ok    = {1'b0, i_idx} < 6'(INT_REGS);
	assign d_ok    = {1'b0, d_idx} < 6'(DATA_REGS);
	assign f_ok    = {1'b0, acc.word.reg_index} < 6'(FLOAT_REGS);
	// The program counter entry is shared, so only lower entries switch banks.
	assign d_super = sup_q && ({1'b0, d_idx} < 6'(DATA_REGS - 1));

	always_comb begin
		i_rd = '0;
		d_rd = '0;
		f_rd = '0;
		if (i_ok) begin
			i_rd = sup_q ? int_super_q[i_idx[IW-1:0]] : int_user_q[i_idx[IW-1:0]];
		end
		if (d_ok) begin
			d_rd = d_super ? data_super_q[d_idx[DSW-1:0]] : data_user_q[d_idx[DW-1:0]];
		end
		if (f_ok) begin
			f_rd = float_q[acc.word.reg_index[FW-1:0]];
		end
	end

	always_comb begin
		rd       = '0;
		i_we     = 1'b0;
		d_we     = 1'b0;
		f_we     = 1'b0;
		flags_we = 1'b0;
		asn_we   = 1'b0;
		sup_we   = 1'b0;
		case (acc.word.target)
			TGT_INT, TGT_LINK: begin
				rd   = {32'd0, i_rd};
				i_we = wr && i_ok;
			end
			TGT_DATA, TGT_SP, TGT_PC: begin
				rd   = {32'd0, d_rd};
				d_we = wr && d_ok;
			end
			TGT_FLOAT: begin
				rd   = f_rd;
				f_we = wr && f_ok;
			end
			TGT_FLAGS: begin
				rd       = {54'd0, sup_q ? flags_super_q : flags_user_q};
				flags_we = wr;
			end
			TGT_ASN: begin
				rd     = {32'd0, asn_q};
				asn_we = wr;
			end
			TGT_SUPER: begin
				rd     = {63'd0, sup_q};
				sup_we = wr;
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	assign result.read_data     = (acc.word.mode == MODE_WRITE) ? 64'd0 : rd;
	assign result.in_supervisor = sup_we ? acc.word.write_value[0] : sup_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < INT_REGS; i++) begin
				int_user_q[i]  <= '0;
				int_super_q[i] <= '0;
			end
			for (int i = 0; i < DATA_REGS; i++) begin
				data_user_q[i] <= (i == DATA_REGS - 1) ? 32'd1 : 32'd0;
			end
			for (int i = 0; i < DATA_REGS - 1; i++) begin
				data_super_q[i] <= '0;
			end
			for (int i = 0; i < FLOAT_REGS; i++) begin
				float_q[i] <= '0;
			end
			flags_user_q  <= '0;
			flags_super_q <= '0;
			sup_q         <= 1'b1;
			asn_q         <= '0;
		end else begin
			if (i_we) begin
				if (sup_q) begin
					int_super_q[i_idx[IW-1:0]] <= v32;
				end else begin
					int_user_q[i_idx[IW-1:0]] <= v32;
				end
			end
			if (d_we) begin
				if (d_super) begin
					data_super_q[d_idx[DSW-1:0]] <= v32;
				end else begin
					data_user_q[d_idx[DW-1:0]] <= v32;
				end
			end
			if (f_we) begin
				float_q[acc.word.reg_index[FW-1:0]] <= acc.word.write_value;
			end
			if (flags_we) begin
				if (sup_q) begin
					flags_super_q <= acc.word.write_value[FLAG_W-1:0];
				end else begin
					flags_user_q <= acc.word.write_value[FLAG_W-1:0];
				end
			end
			if (asn_we) begin
				asn_q <= v32;
			end
			if (sup_we) begin
				sup_q <= acc.word.write_value[0];
			end
		end
	end

	a_sup_only_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		!sup_we |=> $stable(sup_q))
		else $error("supervisor bit changed without a supervisor write");

	a_asn_only_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		!asn_we |=> $stable(asn_q))
		else $error("address-space number changed without a write");

	a_sup_reported: assert property (@(posedge clk) disable iff (!arst_n)
		acc.en |=> (sup_q == $past(result.in_supervisor)))
		else $error("reported supervisor bit differs from the stored one");

endmodule

`default_nettype wire

// ----- rtl/core/banked_register_file_core.sv -----
// Banked register file core, top level: input register, access stage, output register.
// Instantiates brf_store; depends on brf_pkg.
//
// Usage: each request word is one read or one write of a single target (integer,
// data, float, status flags, stack pointer, program counter, link register,
// address-space number or the supervisor bit). Every request gives exactly one
// response word with the read value (zero for a write) and the supervisor bit as
// it stands after the access.
// A word is taken when req_valid is high and req_stall is low; a response is
// delivered when rsp_valid is high and rsp_stall is low.
// Path: a taken request waits in the input register; once the output register has room,
// the access stage performs it and its response is registered in the output register.
// Throughput: one word per cycle while the receiver does not stall; the access stage
// reads and updates the register state as it performs each word, so back-to-back
// words always see the effect of the word before them.
// When the receiver stalls, the response is held, one more request may still be
// taken into the input register, and req_stall rises only when both registers
// are full.
// Reset: all register-file registers clear to zero, except the program counter which reads
// one, and the block starts in supervisor mode. No words are pending.
`default_nettype none

module banked_register_file_core #(
	parameter int INT_REGS   = brf_pkg::INT_REGS_DEF,
	parameter int DATA_REGS  = brf_pkg::DATA_REGS_DEF,
	parameter int FLOAT_REGS = brf_pkg::FLOAT_REGS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire brf_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output brf_pkg::rsp_word_t      rsp
);
	import brf_pkg::*;

	logic      valid_s1;
	req_word_t req_s1;
	logic      valid_s2;
	rsp_word_t rsp_s2;
	logic      adv;
	logic      take;
	access_t   acc;
	rsp_word_t result;

	// The access stage fires when its result has a place to go.
	assign adv       = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign take      = req_valid && !req_stall;

	assign acc.en   = adv;
	assign acc.word = req_s1;

	brf_store #(
		.INT_REGS  (INT_REGS),
		.DATA_REGS (DATA_REGS),
		.FLOAT_REGS(FLOAT_REGS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.acc   (acc),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && rsp_stall))
		else $error("request stalled while a stage had room");

	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("access fired but no response was registered");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_stall && !adv) |=> !valid_s2)
		else $error("delivered response was not retired");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv && !take) |=> (valid_s1 && $stable(req_s1)))
		else $error("pending request lost or changed");

endmodule

`default_nettype wire

// ----- tb/tb_banked_register_file_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for banked_register_file_core: directed and random accesses.
// Depends on brf_pkg and the core; a scoreboard class predicts each response word.

module tb_banked_register_file_core;
	import brf_pkg::*;

	localparam int INT_N          = INT_REGS_DEF;
	localparam int DATA_N         = DATA_REGS_DEF;
	localparam int FP_N           = FLOAT_REGS_DEF;
	localparam int RANDOM_ITEMS   = 500;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	class regfile_scoreboard;
		logic [31:0]       int_usr[INT_N];
		logic [31:0]       int_sup[INT_N];
		logic [31:0]       data_usr[DATA_N];
		logic [31:0]       data_sup[DATA_N - 1];
		logic [63:0]       fp_regs[FP_N];
		logic [FLAG_W-1:0] flags_usr;
		logic [FLAG_W-1:0] flags_sup;
		logic              super_mode;
		logic [31:0]       space_num;
		rsp_word_t         expected_rsp[$];
		int                mismatches;

		function void reset_state();
			foreach (int_usr[i]) begin
				int_usr[i] = '0;
				int_sup[i] = '0;
			end
			foreach (data_usr[i]) data_usr[i] = '0;
			foreach (data_sup[i]) data_sup[i] = '0;
			foreach (fp_regs[i]) fp_regs[i] = '0;
			// The program counter comes out of reset at one.
			data_usr[DATA_N - 1] = 32'd1;
			flags_usr = '0;
			flags_sup = '0;
			super_mode = 1'b1;
			space_num = '0;
			mismatches = 0;
		endfunction

		function logic [63:0] int_file(int idx, logic wr, logic [31:0] v);
			if (idx >= INT_N)
				return '0;
			if (super_mode) begin
				if (wr) int_sup[idx] = v;
				return {32'd0, int_sup[idx]};
			end
			if (wr) int_usr[idx] = v;
			return {32'd0, int_usr[idx]};
		endfunction

		// The last data entry is the program counter and is never banked.
		function logic [63:0] data_file(int idx, logic wr, logic [31:0] v);
			if (idx >= DATA_N)
				return '0;
			if (super_mode && idx < DATA_N - 1) begin
				if (wr) data_sup[idx] = v;
				return {32'd0, data_sup[idx]};
			end
			if (wr) data_usr[idx] = v;
			return {32'd0, data_usr[idx]};
		endfunction

		function void note_access(req_word_t w);
			logic        wr;
			logic [63:0] rd;
			rsp_word_t   r;
			wr = (w.mode == MODE_WRITE);
			rd = '0;
			case (w.target)
			TGT_INT:  rd = int_file(int'(w.reg_index), wr, w.write_value[31:0]);
			TGT_DATA: rd = data_file(int'(w.reg_index), wr, w.write_value[31:0]);
			TGT_SP:   rd = data_file(DATA_N - 2, wr, w.write_value[31:0]);
			TGT_PC:   rd = data_file(DATA_N - 1, wr, w.write_value[31:0]);
			TGT_LINK: rd = int_file(INT_N - 1, wr, w.write_value[31:0]);
			TGT_ASN: begin
				if (wr) space_num = w.write_value[31:0];
				rd = {32'd0, space_num};
			end
			TGT_FLOAT: begin
				if (w.reg_index < FP_N) begin
					if (wr) fp_regs[w.reg_index] = w.write_value;
					rd = fp_regs[w.reg_index];
				end
			end
			TGT_FLAGS: begin
				if (wr) begin
					if (super_mode) flags_sup = w.write_value[FLAG_W-1:0];
					else flags_usr = w.write_value[FLAG_W-1:0];
				end
				rd = {54'd0, super_mode ? flags_sup : flags_usr};
			end
			TGT_SUPER: begin
				if (wr) super_mode = w.write_value[0];
				rd = {63'd0, super_mode};
			end
			default: ;
			endcase
			r.read_data = wr ? '0 : rd;
			r.in_supervisor = super_mode;
			expected_rsp.push_back(r);
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t want;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response word %h arrived with nothing expected", got);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.read_data !== want.read_data || got.in_supervisor !== want.in_supervisor)
			begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: read_data exp %h got %h, in_supervisor exp %b got %b",
						want.read_data, got.read_data, want.in_supervisor, got.in_supervisor);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	logic no_idle;
	logic long_hold;
	int   idle_cycles = 0;

	regfile_scoreboard regs;

	banked_register_file_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic req_word_t make_word(logic m, logic [3:0] t, int idx, logic [63:0] v);
		req_word_t w;
		w.mode = m;
		w.target = t;
		w.reg_index = 5'(idx);
		w.write_value = v;
		return w;
	endfunction

	function automatic req_word_t random_access();
		req_word_t w;
		int        pick;
		pick = $urandom_range(0, 99);
		w.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
		if (pick < 20) w.target = TGT_INT;
		else if (pick < 40) w.target = TGT_DATA;
		else if (pick < 50) w.target = TGT_FLOAT;
		else if (pick < 59) w.target = TGT_FLAGS;
		else if (pick < 66) w.target = TGT_SP;
		else if (pick < 73) w.target = TGT_PC;
		else if (pick < 80) w.target = TGT_LINK;
		else if (pick < 86) w.target = TGT_ASN;
		else if (pick < 95) w.target = TGT_SUPER;
		else w.target = 4'($urandom_range(9, 15));
		// Mostly in-range indexes so that reads find earlier writes.
		if ($urandom_range(0, 6) == 0) w.reg_index = 5'($urandom_range(INT_N, 31));
		else w.reg_index = 5'($urandom_range(0, INT_N - 1));
		case ($urandom_range(0, 3))
		0: w.write_value = '1;
		1: w.write_value = 64'($urandom_range(0, 3));
		default: w.write_value = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// Valid stays high across back-to-back words, so it is only lowered for a gap.
	task automatic send_access(input req_word_t w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		regs.note_access(w);
	endtask

	initial begin : rsp_side
		int hold;
		bit hold_done;
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				hold = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				hold = draw_gap();
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			regs.check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		regs = new();
		regs.reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, bank switching, shared registers and ignored accesses.
		send_access(make_word(MODE_READ, TGT_PC, 0, '0));
		send_access(make_word(MODE_READ, TGT_SUPER, 0, '0));
		send_access(make_word(MODE_READ, TGT_FLAGS, 0, '0));
		send_access(make_word(MODE_WRITE, TGT_INT, 0, '1));
		send_access(make_word(MODE_READ, TGT_INT, 0, '0));
		send_access(make_word(MODE_WRITE, TGT_LINK, 0, 64'hDEAD_BEEF_89AB_CDEF));
		send_access(make_word(MODE_READ, TGT_INT, INT_N - 1, '0));
		send_access(make_word(MODE_WRITE, TGT_SP, 31, 64'h0000_0001_5555_AAAA));
		send_access(make_word(MODE_READ, TGT_DATA, DATA_N - 2, '0));
		send_access(make_word(MODE_WRITE, TGT_INT, 31, '1));
		send_access(make_word(MODE_READ, TGT_INT, INT_N, '0));
		send_access(make_word(MODE_WRITE, TGT_FLOAT, FP_N - 1, '1));
		send_access(make_word(MODE_READ, TGT_FLOAT, FP_N - 1, '0));
		send_access(make_word(MODE_WRITE, TGT_FLAGS, 0, '1));
		send_access(make_word(MODE_READ, TGT_FLAGS, 0, '0));
		send_access(make_word(MODE_WRITE, TGT_SUPER, 0, 64'hFFFF_FFFF_FFFF_FFFE));
		send_access(make_word(MODE_READ, TGT_INT, 0, '0));
		send_access(make_word(MODE_WRITE, TGT_PC, 0, 64'h0000_0000_0000_1234));
		send_access(make_word(MODE_WRITE, TGT_SUPER, 0, 64'd1));
		send_access(make_word(MODE_READ, TGT_PC, 0, '0));
		send_access(make_word(MODE_READ, TGT_DATA, DATA_N - 1, '0));
		send_access(make_word(MODE_WRITE, TGT_ASN, 0, 64'hFFFF_FFFF_8000_0001));
		send_access(make_word(MODE_READ, TGT_ASN, 0, '0));
		send_access(make_word(MODE_WRITE, 4'd15, 31, '1));
		send_access(make_word(MODE_READ, 4'd9, 0, '0));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
			// The receiver holds off while words keep coming, so the core backs up.
			if (i == 200) begin
				long_hold = 1'b1;
				no_idle = 1'b1;
			end
			send_access(random_access());
		end
		req_valid <= 1'b0;

		while (regs.expected_rsp.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (regs.mismatches == 0 && regs.expected_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/brf_pkg.sv
rtl/core/brf_store.sv
rtl/core/banked_register_file_core.sv
tb/tb_banked_register_file_core.sv
